// ===== design/tbq_pkg.sv =====
// Shared types and constants for the three-axis biquad lowpass unit.
// Holds the word layouts, coefficient set, register indexes and reset values.
// No dependencies.
package tbq_pkg;

    // Fixed field widths.
    localparam int SAMPLE_BITS         = 16;
    localparam int COEF_BITS           = 16;
    localparam int COEF_FRAC_BITS_DEF  = 14;
    localparam int NUM_AXES            = 3;
    localparam int NUM_COEFS           = 5;
    localparam int CFG_INDEX_BITS      = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_COEF_ONE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FB_COEF_TWO  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_ZERO = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_ONE  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FF_COEF_TWO  = 3'd4;

    // Coefficient reset values, signed Q2.14.
    localparam logic signed [COEF_BITS-1:0] FB_COEF_ONE_RST  = 16'sd18727;
    localparam logic signed [COEF_BITS-1:0] FB_COEF_TWO_RST  = -16'sd6763;
    localparam logic signed [COEF_BITS-1:0] FF_COEF_ZERO_RST = 16'sd1105;
    localparam logic signed [COEF_BITS-1:0] FF_COEF_ONE_RST  = 16'sd2210;
    localparam logic signed [COEF_BITS-1:0] FF_COEF_TWO_RST  = 16'sd1105;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    // Input word: one sample per axis.
    typedef struct packed {
        sample_t sample_x;
        sample_t sample_y;
        sample_t sample_z;
    } in_word_t;

    // Result word: one filtered value per axis.
    typedef struct packed {
        sample_t filtered_x;
        sample_t filtered_y;
        sample_t filtered_z;
    } out_word_t;

    // The full coefficient set shared by all axes.
    typedef struct packed {
        coef_t fb_coef_one;
        coef_t fb_coef_two;
        coef_t ff_coef_zero;
        coef_t ff_coef_one;
        coef_t ff_coef_two;
    } coef_set_t;

endpackage

// ===== design/tbq_coef_regs.sv =====
// Coefficient register file for the biquad lowpass unit.
// Plain write port; out-of-range indexes are ignored. Depends on tbq_pkg.
module tbq_coef_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [tbq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbq_pkg::COEF_BITS-1:0]       cfg_wdata,
    output tbq_pkg::coef_set_t                  coefs
);
    import tbq_pkg::*;

    coef_set_t coefs_reg;
    coef_set_t coefs_next;

    // Decode the write into the addressed register.
    always_comb begin
        coefs_next = coefs_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FB_COEF_ONE:  coefs_next.fb_coef_one  = cfg_wdata;
                REG_FB_COEF_TWO:  coefs_next.fb_coef_two  = cfg_wdata;
                REG_FF_COEF_ZERO: coefs_next.ff_coef_zero = cfg_wdata;
                REG_FF_COEF_ONE:  coefs_next.ff_coef_one  = cfg_wdata;
                REG_FF_COEF_TWO:  coefs_next.ff_coef_two  = cfg_wdata;
                default:          coefs_next = coefs_reg;
            endcase
        end
    end

    // Reset restores the default lowpass response.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg.fb_coef_one  <= FB_COEF_ONE_RST;
            coefs_reg.fb_coef_two  <= FB_COEF_TWO_RST;
            coefs_reg.ff_coef_zero <= FF_COEF_ZERO_RST;
            coefs_reg.ff_coef_one  <= FF_COEF_ONE_RST;
            coefs_reg.ff_coef_two  <= FF_COEF_TWO_RST;
        end else begin
            coefs_reg <= coefs_next;
        end
    end

    assign coefs = coefs_reg;

endmodule

// ===== design/tbq_axis.sv =====
// One axis of the biquad: history registers and the combinational
// five-tap multiply-accumulate with round-half-up and saturation. Depends on tbq_pkg.
module tbq_axis #(
    parameter int COEF_FRAC_BITS = tbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 advance,
    input  logic                 primed,
    input  tbq_pkg::sample_t     x_in,
    input  tbq_pkg::coef_set_t   coefs,
    output tbq_pkg::sample_t     y_out
);
    import tbq_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W  = PROD_W + 3;
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -SAT_MAX - 1;

    sample_t x1_reg, x2_reg, y1_reg, y2_reg;

    logic signed [PROD_W-1:0] p_y1, p_y2, p_x0, p_x1, p_x2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;
    sample_t                  y_filt;

    // Five independent products, one adder tree, then round and shift.
    always_comb begin
        p_y1    = coefs.fb_coef_one  * y1_reg;
        p_y2    = coefs.fb_coef_two  * y2_reg;
        p_x0    = coefs.ff_coef_zero * x_in;
        p_x1    = coefs.ff_coef_one  * x1_reg;
        p_x2    = coefs.ff_coef_two  * x2_reg;
        acc     = ACC_W'(p_y1) + ACC_W'(p_y2) + ACC_W'(p_x0)
                + ACC_W'(p_x1) + ACC_W'(p_x2) + RND_HALF;
        shifted = acc >>> COEF_FRAC_BITS;
    end

    // Saturate to the sample range.
    always_comb begin
        priority if (shifted > SAT_MAX) begin
            y_filt = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_MIN) begin
            y_filt = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_filt = shifted[SAMPLE_BITS-1:0];
        end
    end

    // The very first sample passes through unchanged.
    assign y_out = primed ? y_filt : x_in;

    // History shifts once per processed word; the first word fills it with itself.
    always_ff @(posedge aclk) begin
        if (advance) begin
            if (!primed) begin
                x1_reg <= x_in;
                x2_reg <= x_in;
                y1_reg <= x_in;
                y2_reg <= x_in;
            end else begin
                x1_reg <= x_in;
                x2_reg <= x1_reg;
                y1_reg <= y_filt;
                y2_reg <= y1_reg;
            end
        end
    end

endmodule

// ===== design/three_axis_biquad_lowpass_unit.sv =====
// Three-axis second-order lowpass (direct form I), top level.
// Input register, three axis datapaths and result register. Depends on tbq_pkg,
// tbq_coef_regs and tbq_axis.
//
// The unit filters each axis of a three-axis sample word with the same biquad
// coefficients. It takes one word per clock unless the result register is full
// and m_ready is low. The input register takes each accepted word, and the
// result register takes its filtered word when that word advances. Throughput
// is set by the per-axis recursion: each axis runs its five products, the sum,
// rounding and saturation combinationally so the new output is in the history
// before the next word is processed. The first word after reset fills the
// history and comes out unchanged. Coefficients are signed Q2.14 and must only
// be written while the unit is idle; reset restores their defaults.
module three_axis_biquad_lowpass_unit #(
    parameter int COEF_FRAC_BITS = tbq_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tbq_pkg::in_word_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output tbq_pkg::out_word_t                  m_data,
    input  logic                                cfg_we,
    input  logic [tbq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbq_pkg::COEF_BITS-1:0]       cfg_wdata
);
    import tbq_pkg::*;

    coef_set_t coefs;
    in_word_t  in_word_reg;
    logic      in_valid_reg;
    out_word_t out_word_reg;
    out_word_t out_word_next;
    logic      out_valid_reg;
    logic      primed_reg;
    logic      advance;
    logic      s_accept;

    // Pipeline control: the input stage moves on whenever the result stage frees.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    tbq_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coefs     (coefs)
    );

    tbq_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_x (
        .aclk    (aclk),
        .advance (advance),
        .primed  (primed_reg),
        .x_in    (in_word_reg.sample_x),
        .coefs   (coefs),
        .y_out   (out_word_next.filtered_x)
    );

    tbq_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_y (
        .aclk    (aclk),
        .advance (advance),
        .primed  (primed_reg),
        .x_in    (in_word_reg.sample_y),
        .coefs   (coefs),
        .y_out   (out_word_next.filtered_y)
    );

    tbq_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_z (
        .aclk    (aclk),
        .advance (advance),
        .primed  (primed_reg),
        .x_in    (in_word_reg.sample_z),
        .coefs   (coefs),
        .y_out   (out_word_next.filtered_z)
    );

    // Input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_word_reg <= s_data;
        end
    end

    // Result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    // Primed after the first processed word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
        end else if (advance) begin
            primed_reg <= 1'b1;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

`ifndef ASSERT_OFF
    // A word in the input stage with a free result stage lands there next cycle.
    a_advance_fills_output: assert property (
        @(posedge aclk) disable iff (!aresetn)
        in_valid_reg && (!out_valid_reg || m_ready) |=> out_valid_reg
    ) else $error("input word did not reach the result stage");

    // The first word after reset comes out unchanged.
    a_first_passthrough: assert property (
        @(posedge aclk) disable iff (!aresetn)
        advance && !primed_reg |=>
            m_data.filtered_x == $past(in_word_reg.sample_x) &&
            m_data.filtered_y == $past(in_word_reg.sample_y) &&
            m_data.filtered_z == $past(in_word_reg.sample_z)
    ) else $error("first word was not passed through");

    // Once primed, the unit stays primed until reset.
    a_primed_sticky: assert property (
        @(posedge aclk) disable iff (!aresetn)
        primed_reg |=> primed_reg
    ) else $error("primed flag dropped without reset");
`endif

endmodule
